// ===== hdl/wc3d_pkg.sv =====
`timescale 1ns / 1ps

package wc3d_pkg;

    // Fixed field widths and default sizing
    localparam int COORD_BITS      = 10;
    localparam int VALUE_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int ACC_HEADROOM    = 32;

    // Sequencer of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_MASS,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ROUND,
        ST_PUSH
    } wc3d_state_t;

    // Axis being worked on
    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    // Divider sequencer
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_CHECK,
        DIV_RUN
    } div_state_t;

    // Divider status toward the top level
    typedef struct packed {
        logic done;
        logic ovf;
    } div_status_t;

endpackage

// ===== hdl/weighted_centroid_3d.sv =====
`timescale 1ns / 1ps
// Voxel word: when it counts toward the sums it is accepted, then multiplied and added per
// axis on one shared multiplier; when the mask drops it, it is only accepted.
// Last voxel: the sums then go through one restoring divider, one quotient bit a cycle,
// one axis after another, plus mass check and push.
// One voxel is in flight at a time; the finished centroid waits in an output register.
// aresetn (synchronous, active low) clears sums, mask_enable, sequencer and valid flags.

module weighted_centroid_3d
    import wc3d_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    // mask_enable register
    input  logic                                              cfg_we,
    input  logic                                              cfg_wdata,
    // voxel stream
    input  logic                                              s_axis_tvalid,
    output logic                                              s_axis_tready,
    // coord_x, coord_y, coord_z, voxel_value, zero pad
    input  logic [((3*COORD_BITS+VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // mask_bit
    input  logic                                              s_axis_tuser,
    // last_voxel
    input  logic                                              s_axis_tlast,
    // centroid stream
    output logic                                              m_axis_tvalid,
    input  logic                                              m_axis_tready,
    // centroid_x, centroid_y, centroid_z, zero pad
    output logic [((3*(COORD_BITS+1+FRAC_BITS)+7)/8)*8-1:0]  m_axis_tdata,
    // zero_mass, clipped
    output logic [1:0]                                        m_axis_tuser
);

    localparam int OUT_BITS   = COORD_BITS + 1 + FRAC_BITS;
    localparam int QUOT_BITS  = OUT_BITS + 1;
    localparam int SHIFT_BITS = COORD_BITS + 1;
    localparam int PROD_BITS  = COORD_BITS + VALUE_BITS + 1;
    localparam int WSUM_BITS  = COORD_BITS + VALUE_BITS + ACC_HEADROOM;
    localparam int MASS_BITS  = VALUE_BITS + ACC_HEADROOM;
    localparam int M_DATA_W   = ((3*OUT_BITS+7)/8)*8;

    localparam logic [QUOT_BITS-1:0] LIM_NEG_MAG = QUOT_BITS'(1) << (OUT_BITS - 1);
    localparam logic [QUOT_BITS-1:0] LIM_POS_MAG = LIM_NEG_MAG - 1'b1;
    localparam logic [OUT_BITS-1:0]  OUT_MIN     = {1'b1, {(OUT_BITS-1){1'b0}}};
    localparam logic [OUT_BITS-1:0]  OUT_MAX     = {1'b0, {(OUT_BITS-1){1'b1}}};

    // Input word fields
    logic [COORD_BITS-1:0]        in_x, in_y, in_z;
    logic signed [VALUE_BITS-1:0] in_value;
    logic                         s_accept;
    logic                         in_counts;

    assign in_x     = s_axis_tdata[COORD_BITS-1:0];
    assign in_y     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_z     = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_value = $signed(s_axis_tdata[3*COORD_BITS+VALUE_BITS-1:3*COORD_BITS]);

    // Sequencer and datapath registers
    wc3d_state_t                  state_reg, state_next;
    axis_t                        step_reg, step_next;
    logic                         mask_en_reg;
    logic [COORD_BITS-1:0]        coord_reg [0:2];
    logic [COORD_BITS-1:0]        coord_next [0:2];
    logic signed [VALUE_BITS-1:0] val_reg, val_next;
    logic                         last_reg, last_next;
    logic signed [PROD_BITS-1:0]  prod_reg, prod_next;
    logic signed [WSUM_BITS-1:0]  wsum_reg [0:2];
    logic signed [WSUM_BITS-1:0]  wsum_next [0:2];
    logic signed [MASS_BITS-1:0]  mass_reg, mass_next;
    logic [MASS_BITS-1:0]         mmag_reg, mmag_next;
    logic                         mneg_reg, mneg_next;
    logic                         sneg_reg, sneg_next;
    logic [OUT_BITS-1:0]          res_reg [0:2];
    logic [OUT_BITS-1:0]          res_next [0:2];
    logic                         zero_reg, zero_next;
    logic                         clip_reg, clip_next;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    logic [3*OUT_BITS-1:0]        m_data_reg, m_data_next;
    logic [1:0]                   m_user_reg, m_user_next;

    // Divider interface
    logic                         div_start;
    logic [WSUM_BITS-1:0]         div_dividend;
    logic [QUOT_BITS-1:0]         div_quot;
    div_status_t                  div_status;

    // Rounding and saturation of one axis
    logic signed [WSUM_BITS-1:0]  wsum_sel;
    logic [WSUM_BITS-1:0]         smag;
    logic [QUOT_BITS:0]           quot_inc;
    logic [QUOT_BITS-1:0]         mag;
    logic [QUOT_BITS-1:0]         mag_neg;
    logic                         res_neg;
    logic [OUT_BITS-1:0]          axis_val;
    logic                         axis_clip;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    // Drop the voxel from the sums when masking is on and it lies outside
    assign in_counts = !(mask_en_reg && !s_axis_tuser);

    assign wsum_sel = wsum_reg[step_reg];
    assign smag     = wsum_sel[WSUM_BITS-1] ? (~wsum_sel + 1'b1) : wsum_sel;

    // Quotient carries one extra fraction bit; add half and drop it to round away from zero
    assign quot_inc = {1'b0, div_quot} + 1'b1;
    assign mag      = quot_inc[QUOT_BITS:1];
    assign mag_neg  = ~mag + 1'b1;
    assign res_neg  = (sneg_reg != mneg_reg) && (div_status.ovf || (mag != '0));

    always_comb begin
        axis_clip = 1'b0;
        axis_val  = mag[OUT_BITS-1:0];
        if (div_status.ovf) begin
            axis_clip = 1'b1;
            axis_val  = res_neg ? OUT_MIN : OUT_MAX;
        end else if (res_neg) begin
            if (mag > LIM_NEG_MAG) begin
                axis_clip = 1'b1;
                axis_val  = OUT_MIN;
            end else begin
                axis_val  = mag_neg[OUT_BITS-1:0];
            end
        end else if (mag > LIM_POS_MAG) begin
            axis_clip = 1'b1;
            axis_val  = OUT_MAX;
        end
    end

    // Next state and datapath control
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        coord_next   = coord_reg;
        val_next     = val_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        wsum_next    = wsum_reg;
        mass_next    = mass_reg;
        mmag_next    = mmag_reg;
        mneg_next    = mneg_reg;
        sneg_next    = sneg_reg;
        res_next     = res_reg;
        zero_next    = zero_reg;
        clip_next    = clip_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        div_start    = 1'b0;
        div_dividend = smag;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    coord_next[0] = in_x;
                    coord_next[1] = in_y;
                    coord_next[2] = in_z;
                    val_next      = in_value;
                    last_next     = s_axis_tlast;
                    step_next     = AXIS_X;
                    if (in_counts) begin
                        mass_next  = mass_reg + MASS_BITS'(in_value);
                        state_next = ST_MUL;
                    end else if (s_axis_tlast) begin
                        state_next = ST_MASS;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = $signed({1'b0, coord_reg[step_reg]}) * val_reg;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                wsum_next[step_reg] = wsum_reg[step_reg] + WSUM_BITS'(prod_reg);
                unique case (step_reg)
                    AXIS_X: begin
                        step_next  = AXIS_Y;
                        state_next = ST_MUL;
                    end
                    AXIS_Y: begin
                        step_next  = AXIS_Z;
                        state_next = ST_MUL;
                    end
                    default: begin
                        step_next  = AXIS_X;
                        state_next = last_reg ? ST_MASS : ST_IDLE;
                    end
                endcase
            end
            ST_MASS: begin
                step_next = AXIS_X;
                clip_next = 1'b0;
                mneg_next = mass_reg[MASS_BITS-1];
                mmag_next = mass_reg[MASS_BITS-1] ? (~mass_reg + 1'b1) : mass_reg;
                if (mass_reg == '0) begin
                    // Zero mass: report zero coordinates and clear the sums
                    zero_next   = 1'b1;
                    res_next[0] = '0;
                    res_next[1] = '0;
                    res_next[2] = '0;
                    wsum_next[0] = '0;
                    wsum_next[1] = '0;
                    wsum_next[2] = '0;
                    state_next  = ST_PUSH;
                end else begin
                    zero_next  = 1'b0;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                sneg_next  = wsum_sel[WSUM_BITS-1];
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_status.done) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                res_next[step_reg] = axis_val;
                clip_next          = clip_reg || axis_clip;
                unique case (step_reg)
                    AXIS_X: begin
                        step_next  = AXIS_Y;
                        state_next = ST_DIV_START;
                    end
                    AXIS_Y: begin
                        step_next  = AXIS_Z;
                        state_next = ST_DIV_START;
                    end
                    default: begin
                        // All axes done: clear the sums for the next volume
                        step_next    = AXIS_X;
                        wsum_next[0] = '0;
                        wsum_next[1] = '0;
                        wsum_next[2] = '0;
                        mass_next    = '0;
                        state_next   = ST_PUSH;
                    end
                endcase
            end
            ST_PUSH: begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_data_next  = {res_reg[2], res_reg[1], res_reg[0]};
                    m_user_next  = {clip_reg, zero_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= AXIS_X;
            mask_en_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            wsum_reg[0] <= '0;
            wsum_reg[1] <= '0;
            wsum_reg[2] <= '0;
            mass_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            wsum_reg    <= wsum_next;
            mass_reg    <= mass_next;
            if (cfg_we) begin
                mask_en_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        coord_reg  <= coord_next;
        val_reg    <= val_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        mmag_reg   <= mmag_next;
        mneg_reg   <= mneg_next;
        sneg_reg   <= sneg_next;
        res_reg    <= res_next;
        zero_reg   <= zero_next;
        clip_reg   <= clip_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // Shared divider: |sum| * 2^(FRAC_BITS+1) / |mass|, one bit a cycle
    wc3d_divider #(
        .SUM_BITS   (WSUM_BITS),
        .DEN_BITS   (MASS_BITS),
        .SHIFT_BITS (SHIFT_BITS),
        .QUOT_BITS  (QUOT_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (mmag_reg),
        .quot     (div_quot),
        .status   (div_status)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_DATA_W'(m_data_reg);
    assign m_axis_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    // A zero-mass word carries zero coordinates and no clip
    a_zero_mass_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
        else $error("zero-mass word with nonzero centroid or clip");

    // Divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider done outside wait state");

    // Sums are clear by the time a result is pushed
    a_sums_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PUSH |-> (mass_reg == '0) && (wsum_reg[0] == '0) &&
            (wsum_reg[1] == '0) && (wsum_reg[2] == '0))
        else $error("sums not cleared before push");

    // A voxel dropped by the mask leaves the mass untouched
    a_masked_voxel: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && mask_en_reg && !s_axis_tuser |=> $stable(mass_reg))
        else $error("masked voxel changed the mass");
`endif

endmodule

// ===== hdl/wc3d_divider.sv =====
`timescale 1ns / 1ps

module wc3d_divider
    import wc3d_pkg::*;
#(
    parameter int SUM_BITS   = COORD_BITS + VALUE_BITS_DEF + ACC_HEADROOM,
    parameter int DEN_BITS   = VALUE_BITS_DEF + ACC_HEADROOM,
    parameter int SHIFT_BITS = COORD_BITS + 1,
    parameter int QUOT_BITS  = COORD_BITS + FRAC_BITS_DEF + 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SUM_BITS-1:0]  dividend,
    input  logic [DEN_BITS-1:0]  divisor,
    output logic [QUOT_BITS-1:0] quot,
    output div_status_t          status
);

    localparam int CMP_BITS = DEN_BITS + SHIFT_BITS;
    localparam int CNT_BITS = $clog2(QUOT_BITS);
    localparam int PAD_BITS = QUOT_BITS - SHIFT_BITS;

    div_state_t            state_reg, state_next;
    logic [SUM_BITS-1:0]   num_reg, num_next;
    logic [DEN_BITS-1:0]   den_reg, den_next;
    logic [DEN_BITS-1:0]   rem_reg, rem_next;
    logic [QUOT_BITS-1:0]  bits_reg, bits_next;
    logic [QUOT_BITS-1:0]  quot_reg, quot_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic                  ovf_reg, ovf_next;

    logic [DEN_BITS:0]     trial;
    logic [DEN_BITS:0]     diff;
    logic                  fits;
    logic                  ovf_hit;

    assign trial   = {rem_reg, bits_reg[QUOT_BITS-1]};
    assign fits    = trial >= {1'b0, den_reg};
    assign diff    = trial - {1'b0, den_reg};
    // Quotient would not fit in QUOT_BITS: dividend >= divisor << SHIFT_BITS
    assign ovf_hit = CMP_BITS'(num_reg) >= {den_reg, {SHIFT_BITS{1'b0}}};

    always_comb begin
        state_next = state_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        bits_next  = bits_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    num_next   = dividend;
                    den_next   = divisor;
                    state_next = DIV_CHECK;
                end
            end
            DIV_CHECK: begin
                ovf_next  = ovf_hit;
                rem_next  = DEN_BITS'(num_reg >> SHIFT_BITS);
                bits_next = QUOT_BITS'(num_reg[SHIFT_BITS-1:0]) << PAD_BITS;
                quot_next = '0;
                cnt_next  = CNT_BITS'(QUOT_BITS - 1);
                if (ovf_hit) begin
                    done_next  = 1'b1;
                    state_next = DIV_IDLE;
                end else begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                // One restoring step: shift in the next dividend bit
                rem_next  = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
                quot_next = {quot_reg[QUOT_BITS-2:0], fits};
                bits_next = bits_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = DIV_IDLE;
                end
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
        ovf_reg  <= ovf_next;
    end

    assign quot        = quot_reg;
    assign status.done = done_reg;
    assign status.ovf  = ovf_reg;

endmodule

// ===== tb/weighted_centroid_3d_test.sv =====
`timescale 1ns / 1ps

module weighted_centroid_3d_test;
    import wc3d_pkg::*;

    // Sizing of the block under test (defaults of the top level)
    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam int FRAC_BITS  = FRAC_BITS_DEF;
    localparam int OUT_BITS   = COORD_BITS + 1 + FRAC_BITS;
    localparam int WSUM_BITS  = 58;
    localparam int MASS_BITS  = 48;
    localparam int S_DATA_W   = ((3*COORD_BITS+VALUE_BITS+7)/8)*8;
    localparam int M_DATA_W   = ((3*OUT_BITS+7)/8)*8;

    // Run control
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int TAIL_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 235;

    typedef struct packed {
        logic [COORD_BITS-1:0]        x;
        logic [COORD_BITS-1:0]        y;
        logic [COORD_BITS-1:0]        z;
        logic signed [VALUE_BITS-1:0] value;
        logic                         in_mask;
        logic                         last;
    } voxel_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] cx;
        logic signed [OUT_BITS-1:0] cy;
        logic signed [OUT_BITS-1:0] cz;
        logic                       zero_mass;
        logic                       clipped;
    } centroid_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SOURCE,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int {
        MIX_POSITIVE,
        MIX_SIGNED,
        MIX_TINY,
        MIX_EXTREME
    } value_mix_t;

    // Tracks the running sums of the volume and the centroids still owed by the block
    class centroid_tracker;
        logic [WSUM_BITS-1:0] sum_x;
        logic [WSUM_BITS-1:0] sum_y;
        logic [WSUM_BITS-1:0] sum_z;
        logic [MASS_BITS-1:0] mass;
        bit                   mask_en;
        centroid_t            expected_q[$];
        int                   errors;
        int                   results;
        int                   clips;
        int                   empties;

        function new();
            clear_sums();
            mask_en = 1'b0;
            errors  = 0;
            results = 0;
            clips   = 0;
            empties = 0;
        endfunction

        function void clear_sums();
            sum_x = '0;
            sum_y = '0;
            sum_z = '0;
            mass  = '0;
        endfunction

        // Rounded, saturated sum * 2^FRAC_BITS / mass for one axis
        function logic [OUT_BITS-1:0] fixed_quotient(logic [WSUM_BITS-1:0] sum,
                                                     logic [63:0] mmag, bit mneg,
                                                     inout bit clip);
            logic [WSUM_BITS-1:0] smag_n;
            logic [63:0]          smag;
            logic [63:0]          q;
            logic [63:0]          r;
            logic [63:0]          mag;
            logic [63:0]          lim_pos;
            bit                   neg;
            int                   i;
            smag_n  = sum[WSUM_BITS-1] ? -sum : sum;
            smag    = 64'(smag_n);
            neg     = (sum[WSUM_BITS-1] != mneg);
            lim_pos = (64'd1 << (OUT_BITS-1)) - 64'd1;
            q = smag / mmag;
            r = smag % mmag;
            if (q > (64'd1 << (OUT_BITS+1)))
                q = 64'd1 << (OUT_BITS+1);
            for (i = 0; i < FRAC_BITS + 1; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= mmag) begin
                    r = r - mmag;
                    q = q | 64'd1;
                end
            end
            mag = (q + 64'd1) >> 1;
            if (mag == 64'd0)
                neg = 1'b0;
            if (neg) begin
                if (mag > lim_pos + 64'd1) begin
                    mag  = lim_pos + 64'd1;
                    clip = 1'b1;
                end
                return OUT_BITS'(-mag);
            end
            if (mag > lim_pos) begin
                mag  = lim_pos;
                clip = 1'b1;
            end
            return OUT_BITS'(mag);
        endfunction

        function void add_voxel(voxel_t v);
            longint               w;
            centroid_t            c;
            logic [MASS_BITS-1:0] m;
            logic [63:0]          mmag;
            bit                   mneg;
            bit                   clip;
            w = longint'(v.value);
            if (!(mask_en && !v.in_mask)) begin
                sum_x = sum_x + WSUM_BITS'(longint'(v.x) * w);
                sum_y = sum_y + WSUM_BITS'(longint'(v.y) * w);
                sum_z = sum_z + WSUM_BITS'(longint'(v.z) * w);
                mass  = mass + MASS_BITS'(w);
            end
            if (!v.last)
                return;
            c = '0;
            if (mass == '0) begin
                c.zero_mass = 1'b1;
            end else begin
                mneg = mass[MASS_BITS-1];
                m    = mneg ? -mass : mass;
                mmag = 64'(m);
                clip = 1'b0;
                c.cx = fixed_quotient(sum_x, mmag, mneg, clip);
                c.cy = fixed_quotient(sum_y, mmag, mneg, clip);
                c.cz = fixed_quotient(sum_z, mmag, mneg, clip);
                c.clipped = clip;
            end
            expected_q.push_back(c);
            clear_sums();
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_centroid(logic [M_DATA_W-1:0] data, logic [1:0] flags);
            centroid_t want;
            centroid_t got;
            got.cx        = data[OUT_BITS-1:0];
            got.cy        = data[2*OUT_BITS-1:OUT_BITS];
            got.cz        = data[3*OUT_BITS-1:2*OUT_BITS];
            got.zero_mass = flags[0];
            got.clipped   = flags[1];
            if (expected_q.size() == 0) begin
                $error("centroid word arrived with none outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results++;
            if (want.clipped)
                clips++;
            if (want.zero_mass)
                empties++;
            compare_field("centroid_x", want.cx, got.cx);
            compare_field("centroid_y", want.cy, got.cy);
            compare_field("centroid_z", want.cz, got.cz);
            compare_field("zero_mass", want.zero_mass, got.zero_mass);
            compare_field("clipped", want.clipped, got.clipped);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic                cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                s_axis_tuser;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    centroid_tracker tracker;
    int              src_idle_pct;
    int              sink_stall_pct;
    int              items_sent;
    int              phases_run;
    int              cycle_count;

    weighted_centroid_3d u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // coord_x, coord_y, coord_z, voxel_value, zero pad
        .s_axis_tuser  (s_axis_tuser),   // mask_bit
        .s_axis_tlast  (s_axis_tlast),   // last_voxel
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // centroid_x, centroid_y, centroid_z, zero pad
        .m_axis_tuser  (m_axis_tuser)    // zero_mass, clipped
    );

    // 20 ns clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver: stall at random per cycle, change tready only on the falling edge
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Sample accepted centroid words on the rising edge and check them in order
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            tracker.check_centroid(m_axis_tdata, m_axis_tuser);
    end

    // Watchdog: end the run as failed when the overall cycle limit runs out
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d centroids outstanding",
                 cycle_count, tracker.pending());
        $display("weighted_centroid_3d_test NOT OK");
        $finish;
    end

    function automatic voxel_t voxel_at(int x, int y, int z, int value, bit in_mask, bit last);
        voxel_t v;
        v.x       = COORD_BITS'(x);
        v.y       = COORD_BITS'(y);
        v.z       = COORD_BITS'(z);
        v.value   = VALUE_BITS'(value);
        v.in_mask = in_mask;
        v.last    = last;
        return v;
    endfunction

    // Mostly uniform indices, with the grid edges now and then
    function automatic logic [COORD_BITS-1:0] pick_coord();
        if ($urandom_range(6) == 0)
            return $urandom_range(1) ? {COORD_BITS{1'b1}} : {COORD_BITS{1'b0}};
        return COORD_BITS'($urandom());
    endfunction

    function automatic voxel_t random_voxel(value_mix_t mix, bit last);
        voxel_t v;
        v.x = pick_coord();
        v.y = pick_coord();
        v.z = pick_coord();
        case (mix)
            MIX_POSITIVE: begin
                // positive masses keep the centroid inside the grid
                v.value = ($urandom_range(3) == 0) ? VALUE_BITS'($urandom_range(1, 32767))
                                                   : VALUE_BITS'($urandom_range(1, 255));
            end
            MIX_SIGNED: begin
                v.value = VALUE_BITS'($urandom());
            end
            MIX_TINY: begin
                // -1, 0, +1: small masses, frequent zero totals and saturation
                v.value = VALUE_BITS'(int'($urandom_range(2)) - 1);
            end
            default: begin
                case ($urandom_range(4))
                    0: v.value = {1'b1, {(VALUE_BITS-1){1'b0}}};
                    1: v.value = {1'b0, {(VALUE_BITS-1){1'b1}}};
                    2: v.value = '1;
                    3: v.value = '0;
                    default: v.value = VALUE_BITS'(1);
                endcase
            end
        endcase
        v.in_mask = ($urandom_range(3) != 0);
        v.last    = last;
        return v;
    endfunction

    // Present one voxel word; entered and left at a falling edge with tvalid still high
    task automatic send_voxel(voxel_t v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_DATA_W'({v.value, v.z, v.y, v.x});
        s_axis_tuser  <= v.in_mask;
        s_axis_tlast  <= v.last;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        tracker.add_voxel(v);
        items_sent++;
        @(negedge aclk);
    endtask

    // Drop tvalid and hold off until every owed centroid has come back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (tracker.pending() != 0)
            @(negedge aclk);
    endtask

    // Write mask_enable only once the block has gone quiet
    task automatic write_mask(bit en);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        tracker.mask_en = en;
    endtask

    // One random phase: volumes of random length, one value mix per volume
    task automatic run_phase(idle_mode_t mode, bit mask);
        int         sent;
        int         len;
        int         i;
        bit         paused;
        value_mix_t mix;
        write_mask(mask);
        src_idle_pct   = (mode == IDLE_SOURCE) ? 81 : (mode == IDLE_BOTH) ? 31 : 0;
        sink_stall_pct = (mode == IDLE_SINK)   ? 81 : (mode == IDLE_BOTH) ? 31 : 0;
        sent   = 0;
        paused = 1'b0;
        while (sent < ITEMS_PER_PHASE) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
            mix = value_mix_t'($urandom_range(3));
            for (i = 0; i < len; i++)
                send_voxel(random_voxel(mix, i == len - 1));
            sent += len;
            // hold the sender once mid-phase until the result side is empty
            if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end
        phases_run++;
    endtask

    initial begin
        int drain_cycles;
        tracker        = new();
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        s_axis_tlast   = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        items_sent     = 0;
        phases_run     = 0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed volumes, mask off (reset value)
        send_voxel(voxel_at(1023, 1023, 1023, 32767, 1'b1, 1'b1));  // largest in-range centroid
        send_voxel(voxel_at(0, 0, 0, -32768, 1'b0, 1'b1));          // most negative value
        send_voxel(voxel_at(5, 6, 7, 0, 1'b1, 1'b1));               // zero mass
        send_voxel(voxel_at(1023, 0, 512, 3, 1'b1, 1'b0));          // mass 1: saturate high
        send_voxel(voxel_at(0, 1023, 0, -2, 1'b1, 1'b1));
        send_voxel(voxel_at(1023, 1023, 1023, 3, 1'b1, 1'b0));      // mass -1: saturate low
        send_voxel(voxel_at(0, 0, 0, -4, 1'b1, 1'b1));
        send_voxel(voxel_at(1, 2, 3, 2, 1'b1, 1'b0));
        send_voxel(voxel_at(2, 3, 4, 1, 1'b1, 1'b0));
        send_voxel(voxel_at(0, 0, 0, 1, 1'b0, 1'b1));
        send_voxel(voxel_at(1023, 1023, 1023, -32768, 1'b1, 1'b0)); // negative mass and sums
        send_voxel(voxel_at(1023, 1023, 1023, -32768, 1'b1, 1'b1));
        send_voxel(voxel_at(1, 1, 1, 1, 1'b1, 1'b0));
        send_voxel(voxel_at(3, 3, 3, 1, 1'b1, 1'b1));
        send_voxel(voxel_at(1, 0, 0, 1, 1'b1, 1'b0));               // half LSB tie, positive
        send_voxel(voxel_at(0, 0, 0, 511, 1'b1, 1'b1));
        send_voxel(voxel_at(1, 0, 0, -1, 1'b1, 1'b0));              // half LSB tie, negative
        send_voxel(voxel_at(0, 0, 0, 513, 1'b1, 1'b1));

        // Directed volumes, mask on
        write_mask(1'b1);
        send_voxel(voxel_at(100, 200, 300, 500, 1'b1, 1'b0));
        send_voxel(voxel_at(900, 900, 900, 32767, 1'b0, 1'b1));     // skipped voxel still ends it
        send_voxel(voxel_at(10, 10, 10, 7, 1'b0, 1'b1));            // all skipped: zero mass
        send_voxel(voxel_at(1, 1, 1, 2, 1'b1, 1'b0));
        send_voxel(voxel_at(2, 2, 2, 3, 1'b1, 1'b1));

        // Random phases over all idle patterns and both mask settings
        run_phase(IDLE_NONE, 1'b0);
        run_phase(IDLE_SOURCE, 1'b1);
        run_phase(IDLE_SINK, 1'b0);
        run_phase(IDLE_BOTH, 1'b1);
        run_phase(IDLE_NONE, 1'b1);
        run_phase(IDLE_BOTH, 1'b0);

        s_axis_tvalid <= 1'b0;
        drain_cycles = 0;
        while (tracker.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.pending() != 0) begin
            $error("%0d centroid words never arrived", tracker.pending());
            tracker.errors += tracker.pending();
        end

        $display("Streamed %0d voxel words in %0d random phases plus directed volumes,",
                 items_sent, phases_run);
        $display("checked %0d centroids (%0d saturated, %0d with zero mass), %0d mismatches",
                 tracker.results, tracker.clips, tracker.empties, tracker.errors);
        if (tracker.errors == 0)
            $display("weighted_centroid_3d_test OK");
        else
            $display("weighted_centroid_3d_test NOT OK");
        $finish;
    end

endmodule
